### design/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/mafq_pkg.sv
package mafq_pkg;

  localparam int MAX_FRAME_LEN = 512;
  localparam int CNT_W         = $clog2(MAX_FRAME_LEN + 1);
  localparam int FRAME_LEN_W   = 10;
  localparam int CMP_W         = (CNT_W > 10) ? CNT_W : 10;

  // item kinds
  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // verdict codes
  localparam logic [2:0] ST_ACCEPT    = 3'd0;
  localparam logic [2:0] ST_DELIM     = 3'd1;
  localparam logic [2:0] ST_ADDRESS   = 3'd2;
  localparam logic [2:0] ST_FUNCTION  = 3'd3;
  localparam logic [2:0] ST_LENGTH    = 3'd4;
  localparam logic [2:0] ST_BUSY      = 3'd5;
  localparam logic [2:0] ST_HEX       = 3'd6;

  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] RESET_ADDR   = 8'h7E;

  localparam logic [7:0] FN_FIRST_FIXED = 8'h01;
  localparam logic [7:0] FN_LAST_FIXED  = 8'h06;
  localparam logic [7:0] FN_WRITE_COILS = 8'h0F;
  localparam logic [7:0] FN_WRITE_REGS  = 8'h10;

  localparam int FIXED_FRAME_LEN = 17;
  localparam int WIDE_FRAME_BASE = 19;

  // character positions of decoded fields
  localparam int POS_ADDR_HI = 1;
  localparam int POS_ADDR_LO = 2;
  localparam int POS_FUNC_HI = 3;
  localparam int POS_FUNC_LO = 4;
  localparam int POS_BC_HI   = 13;
  localparam int POS_BC_LO   = 14;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [7:0]       first;
    logic [15:0]      last2;
    logic [7:0]       addr;
    logic [7:0]       func;
    logic [7:0]       nbytes;
    logic             hex_err;
  } frame_t;

  // {bad, nibble}; bad set for anything that is not a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else begin
      r = 5'b1_0000;
    end
    return r;
  endfunction

endpackage

### design/modbus_ascii_frame_qualifier_core.sv
// A line-idle item shows its verdict on out_* in the cycle after it is accepted.
// Throughput: one item per cycle while in_ready is high; each character is a counter step and a hex decode.
// in_ready drops only while a verdict sits in the output register and out_ready is low.
// Reset (rst_n low, synchronous): frame state and pending flag clear, output empty,
// slave address back to 0x7E.
`include "assert_macros.svh"

module modbus_ascii_frame_qualifier_core (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic [7:0] cfg_slave_address,
  // character / control items
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_data_byte,
  // verdicts
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [9:0] out_frame_length,
  output logic [7:0] out_function_code
);

  // frame collection state
  mafq_pkg::frame_t frame_r, frame_nxt;
  logic [3:0]       hold_r, hold_nxt;
  logic             pending_r, pending_nxt;
  logic [7:0]       slave_addr_r;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] status_r, status_nxt;
  logic [9:0] len_r, len_nxt;
  logic [7:0] func_r, func_nxt;

  logic       in_fire;
  logic [2:0] verdict;
  logic [4:0] hex;
  logic [3:0] nib;
  logic       wide;
  logic       is_decoded;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  mafq_verdict u_verdict (
    .frame         (frame_r),
    .slave_address (slave_addr_r),
    .status        (verdict)
  );

  assign hex  = mafq_pkg::hex_decode(in_data_byte);
  assign nib  = hex[4] ? 4'd0 : hex[3:0];
  assign wide = (frame_r.func == mafq_pkg::FN_WRITE_COILS) ||
                (frame_r.func == mafq_pkg::FN_WRITE_REGS);

  // positions that take a hex digit
  always_comb begin
    is_decoded = 1'b0;
    if (frame_r.count == mafq_pkg::CNT_W'(mafq_pkg::POS_ADDR_HI) ||
        frame_r.count == mafq_pkg::CNT_W'(mafq_pkg::POS_ADDR_LO) ||
        frame_r.count == mafq_pkg::CNT_W'(mafq_pkg::POS_FUNC_HI) ||
        frame_r.count == mafq_pkg::CNT_W'(mafq_pkg::POS_FUNC_LO)) begin
      is_decoded = 1'b1;
    end else if (wide && (frame_r.count == mafq_pkg::CNT_W'(mafq_pkg::POS_BC_HI) ||
                          frame_r.count == mafq_pkg::CNT_W'(mafq_pkg::POS_BC_LO))) begin
      is_decoded = 1'b1;
    end
  end

  always_comb begin
    frame_nxt     = frame_r;
    hold_nxt      = hold_r;
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    len_nxt       = len_r;
    func_nxt      = func_r;

    if (in_fire) begin
      case (in_kind)
        mafq_pkg::KIND_CHAR: begin
          // characters are dropped while an accepted frame waits for release
          if (!pending_r) begin
            if (frame_r.count >= mafq_pkg::CNT_W'(mafq_pkg::MAX_FRAME_LEN)) begin
              // overflow: count saturates, frame is flagged as bad hex
              frame_nxt.hex_err = 1'b1;
            end else begin
              if (frame_r.count == '0) begin
                frame_nxt.first = in_data_byte;
              end
              frame_nxt.last2 = {frame_r.last2[7:0], in_data_byte};
              if (is_decoded && hex[4]) begin
                frame_nxt.hex_err = 1'b1;
              end
              if (frame_r.count == mafq_pkg::CNT_W'(mafq_pkg::POS_ADDR_HI) ||
                  frame_r.count == mafq_pkg::CNT_W'(mafq_pkg::POS_FUNC_HI) ||
                  (wide && frame_r.count == mafq_pkg::CNT_W'(mafq_pkg::POS_BC_HI))) begin
                hold_nxt = nib;
              end else if (frame_r.count == mafq_pkg::CNT_W'(mafq_pkg::POS_ADDR_LO)) begin
                frame_nxt.addr = {hold_r, nib};
              end else if (frame_r.count == mafq_pkg::CNT_W'(mafq_pkg::POS_FUNC_LO)) begin
                frame_nxt.func = {hold_r, nib};
              end else if (wide && frame_r.count == mafq_pkg::CNT_W'(mafq_pkg::POS_BC_LO)) begin
                frame_nxt.nbytes = {hold_r, nib};
              end
              frame_nxt.count = frame_r.count + 1'b1;
            end
          end
        end
        mafq_pkg::KIND_END: begin
          out_valid_nxt = 1'b1;
          if (pending_r) begin
            status_nxt = mafq_pkg::ST_BUSY;
            len_nxt    = '0;
            func_nxt   = '0;
          end else begin
            status_nxt = verdict;
            len_nxt    = mafq_pkg::FRAME_LEN_W'(frame_r.count);
            func_nxt   = frame_r.func;
            if (verdict == mafq_pkg::ST_ACCEPT) begin
              pending_nxt = 1'b1;
            end
            frame_nxt = '0;
            hold_nxt  = '0;
          end
        end
        mafq_pkg::KIND_RELEASE: begin
          pending_nxt = 1'b0;
        end
        default: begin
          // unused kind: no effect
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r      <= '0;
      hold_r       <= '0;
      pending_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      slave_addr_r <= mafq_pkg::RESET_ADDR;
    end else begin
      frame_r     <= frame_nxt;
      hold_r      <= hold_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        slave_addr_r <= cfg_slave_address;
      end
    end
  end

  // verdict payload, no reset needed
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    len_r    <= len_nxt;
    func_r   <= func_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_frame_length  = len_r;
  assign out_function_code = func_r;

  `ASSERT_CLK(a_accept_sets_pending, clk, rst_n,
    in_fire && in_kind == mafq_pkg::KIND_END && !pending_r &&
    verdict == mafq_pkg::ST_ACCEPT |=> pending_r,
    "accepted frame did not become pending")
  `ASSERT_CLK(a_pending_drops_chars, clk, rst_n,
    pending_r && in_fire && in_kind == mafq_pkg::KIND_CHAR |=> $stable(frame_r),
    "character changed frame state while a frame was pending")
  `ASSERT_CLK(a_count_bounded, clk, rst_n,
    frame_r.count <= mafq_pkg::CNT_W'(mafq_pkg::MAX_FRAME_LEN),
    "character count beyond buffer length")
  `ASSERT_CLK(a_busy_payload_zero, clk, rst_n,
    out_valid_r && status_r == mafq_pkg::ST_BUSY |-> len_r == '0 && func_r == '0,
    "busy verdict carries frame data")

endmodule

### design/mafq_verdict.sv
// Frame verdict from the collected frame fields.
module mafq_verdict (
  input  mafq_pkg::frame_t frame,
  input  logic [7:0]       slave_address,
  output logic [2:0]       status
);

  logic [mafq_pkg::CMP_W-1:0] count_ext;
  logic [mafq_pkg::CMP_W-1:0] wide_len;
  logic                       fixed_fn;
  logic                       wide_fn;

  assign count_ext = mafq_pkg::CMP_W'(frame.count);
  assign wide_len  = mafq_pkg::CMP_W'(mafq_pkg::WIDE_FRAME_BASE)
                   + mafq_pkg::CMP_W'({frame.nbytes, 1'b0});
  assign fixed_fn  = (frame.func >= mafq_pkg::FN_FIRST_FIXED) &&
                     (frame.func <= mafq_pkg::FN_LAST_FIXED);
  assign wide_fn   = (frame.func == mafq_pkg::FN_WRITE_COILS) ||
                     (frame.func == mafq_pkg::FN_WRITE_REGS);

  always_comb begin
    if ((count_ext < mafq_pkg::CMP_W'(3)) || (frame.first != mafq_pkg::CH_COLON) ||
        (frame.last2 != {mafq_pkg::CH_CR, mafq_pkg::CH_LF})) begin
      status = mafq_pkg::ST_DELIM;
    end else if (frame.hex_err) begin
      status = mafq_pkg::ST_HEX;
    end else if (frame.addr != slave_address) begin
      status = mafq_pkg::ST_ADDRESS;
    end else if (fixed_fn) begin
      status = (count_ext == mafq_pkg::CMP_W'(mafq_pkg::FIXED_FRAME_LEN)) ?
               mafq_pkg::ST_ACCEPT : mafq_pkg::ST_LENGTH;
    end else if (wide_fn) begin
      status = (count_ext == wide_len) ? mafq_pkg::ST_ACCEPT : mafq_pkg::ST_LENGTH;
    end else begin
      status = mafq_pkg::ST_FUNCTION;
    end
  end

endmodule

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // kind code the block has no use for; it must be ignored
  localparam logic [1:0] KIND_NOISE = 2'd3;

  localparam int RANDOM_ITEMS = 800;
  localparam int PHASES       = 5;
  localparam int RUN_LIMIT_NS = 10_000_000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } rx_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [9:0] length;
    logic [7:0] func;
  } verdict_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       cfg_we            = 1'b0;
  logic [7:0] cfg_slave_address = 8'h00;
  logic       in_valid          = 1'b0;
  logic       in_ready;
  logic [1:0] in_kind           = mafq_pkg::KIND_CHAR;
  logic [7:0] in_data_byte      = 8'h00;
  logic       out_valid;
  logic       out_ready         = 1'b0;
  logic [2:0] out_status;
  logic [9:0] out_frame_length;
  logic [7:0] out_function_code;

  modbus_ascii_frame_qualifier_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_slave_address (cfg_slave_address),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_frame_length  (out_frame_length),
    .out_function_code (out_function_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor: shadow copy of the character collector and its verdict
  // ---------------------------------------------------------------------------
  logic [7:0]  model_station = mafq_pkg::RESET_ADDR;
  int          frm_count     = 0;
  logic [7:0]  frm_first     = 8'h00;
  logic [15:0] frm_tail      = 16'h0000;   // older character in the high byte
  logic [3:0]  frm_hold      = 4'h0;
  logic [7:0]  frm_addr      = 8'h00;
  logic [7:0]  frm_func      = 8'h00;
  logic [7:0]  frm_bc        = 8'h00;
  bit          frm_bad       = 1'b0;       // bad hex digit or overflow seen
  bit          held          = 1'b0;       // accepted frame awaiting release

  verdict_t    verdicts_due[$];
  int          mismatches    = 0;

  // {not_hex, nibble}; letters of either case share the low nibble trick
  function automatic logic [4:0] glyph_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  task automatic forget_frame();
    frm_count = 0;
    frm_first = 8'h00;
    frm_tail  = 16'h0000;
    frm_hold  = 4'h0;
    frm_addr  = 8'h00;
    frm_func  = 8'h00;
    frm_bc    = 8'h00;
    frm_bad   = 1'b0;
  endtask

  task automatic absorb_char(input logic [7:0] c);
    int         at;
    bit         wide;
    bit         decoded;
    logic [4:0] g;
    logic [3:0] nib;
    at   = frm_count;
    wide = (frm_func == mafq_pkg::FN_WRITE_COILS || frm_func == mafq_pkg::FN_WRITE_REGS);
    // past the buffer: drop the character, flag the frame
    if (at >= mafq_pkg::MAX_FRAME_LEN) begin
      frm_bad = 1'b1;
      return;
    end
    if (at == 0) frm_first = c;
    frm_tail = {frm_tail[7:0], c};
    decoded = (at >= mafq_pkg::POS_ADDR_HI && at <= mafq_pkg::POS_FUNC_LO) ||
              (wide && (at == mafq_pkg::POS_BC_HI || at == mafq_pkg::POS_BC_LO));
    g   = glyph_value(c);
    nib = g[4] ? 4'h0 : g[3:0];
    if (decoded && g[4]) frm_bad = 1'b1;
    if (at == mafq_pkg::POS_ADDR_HI || at == mafq_pkg::POS_FUNC_HI ||
        (wide && at == mafq_pkg::POS_BC_HI))
      frm_hold = nib;
    else if (at == mafq_pkg::POS_ADDR_LO)
      frm_addr = {frm_hold, nib};
    else if (at == mafq_pkg::POS_FUNC_LO)
      frm_func = {frm_hold, nib};
    else if (wide && at == mafq_pkg::POS_BC_LO)
      frm_bc = {frm_hold, nib};
    frm_count = at + 1;
  endtask

  // checks in priority order: framing, hex/overflow, address, function, length
  function automatic logic [2:0] judge_frame();
    if (frm_count < 3 || frm_first != mafq_pkg::CH_COLON ||
        frm_tail != {mafq_pkg::CH_CR, mafq_pkg::CH_LF})
      return mafq_pkg::ST_DELIM;
    if (frm_bad) return mafq_pkg::ST_HEX;
    if (frm_addr != model_station) return mafq_pkg::ST_ADDRESS;
    if (frm_func >= mafq_pkg::FN_FIRST_FIXED && frm_func <= mafq_pkg::FN_LAST_FIXED)
      return (frm_count == mafq_pkg::FIXED_FRAME_LEN) ?
             mafq_pkg::ST_ACCEPT : mafq_pkg::ST_LENGTH;
    if (frm_func == mafq_pkg::FN_WRITE_COILS || frm_func == mafq_pkg::FN_WRITE_REGS)
      return (frm_count == mafq_pkg::WIDE_FRAME_BASE + 2 * int'(frm_bc)) ?
             mafq_pkg::ST_ACCEPT : mafq_pkg::ST_LENGTH;
    return mafq_pkg::ST_FUNCTION;
  endfunction

  task automatic predict_item(input logic [1:0] kind, input logic [7:0] data);
    verdict_t v;
    case (kind)
      mafq_pkg::KIND_CHAR: begin
        if (!held) absorb_char(data);
      end
      mafq_pkg::KIND_RELEASE: begin
        held = 1'b0;
      end
      mafq_pkg::KIND_END: begin
        if (held) begin
          // busy: frame state untouched, nothing was collected anyway
          v.status = mafq_pkg::ST_BUSY;
          v.length = '0;
          v.func   = '0;
        end else begin
          v.status = judge_frame();
          v.length = frm_count[9:0];
          v.func   = frm_func;
          if (v.status == mafq_pkg::ST_ACCEPT) held = 1'b1;
          forget_frame();
        end
        verdicts_due.push_back(v);
      end
      default: ;
    endcase
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      $error("unexpected verdict: status %0d frame_length %0d function_code %0d",
             out_status, out_frame_length, out_function_code);
      mismatches++;
      return;
    end
    want = verdicts_due.pop_front();
    if (out_status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, out_status);
      mismatches++;
    end
    if (out_frame_length !== want.length) begin
      $error("frame_length: expected %0d, got %0d", want.length, out_frame_length);
      mismatches++;
    end
    if (out_function_code !== want.func) begin
      $error("function_code: expected %0d, got %0d", want.func, out_function_code);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Rising edge: handshakes are sampled here, config writes mirrored,
  // verdicts checked and accepted items fed to the predictor.
  // ---------------------------------------------------------------------------
  bit in_taken       = 1'b0;
  bit out_taken      = 1'b0;
  int items_accepted = 0;

  always @(posedge clk) begin
    in_taken  = in_valid && in_ready;
    out_taken = out_valid && out_ready;
    if (rst_n) begin
      if (cfg_we) model_station = cfg_slave_address;
      if (out_taken) check_verdict();
      if (in_taken) begin
        predict_item(in_kind, in_data_byte);
        items_accepted++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idle pacing, shared by both sides. Runs of items are drawn as either
  // back-to-back or gapped so gaps land on every phase of a frame.
  // ---------------------------------------------------------------------------
  function automatic int pace(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(10, 150);
      calm = ($urandom_range(0, 2) == 0);
    end
    left--;
    if (calm) return 0;
    return $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(0, 14);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops pending items at the falling edge, holds each until taken
  // ---------------------------------------------------------------------------
  rx_item_t pending_items[$];
  int       items_queued  = 0;
  int       in_wait       = 0;
  int       in_run_left   = 0;
  bit       in_calm       = 1'b0;

  always @(negedge clk) begin : drv
    rx_item_t nxt;
    logic     drive_valid;
    drive_valid = in_valid && !in_taken;  // current item still waiting
    if (rst_n && !drive_valid) begin
      if (in_wait > 0) begin
        in_wait--;
      end else if (pending_items.size() > 0) begin
        nxt          = pending_items.pop_front();
        in_kind      <= nxt.kind;
        in_data_byte <= nxt.data;
        drive_valid  = 1'b1;
        in_wait      = pace(in_run_left, in_calm);
      end
    end
    in_valid <= drive_valid;
  end

  // ---------------------------------------------------------------------------
  // Verdict receiver: after each verdict, stall a drawn number of cycles
  // counted only while a verdict is actually on offer.
  // ---------------------------------------------------------------------------
  int out_wait     = 0;
  int out_run_left = 0;
  bit out_calm     = 1'b0;

  always @(negedge clk) begin : rcv
    if (out_taken) out_wait = pace(out_run_left, out_calm);
    if (out_wait > 0 && out_valid === 1'b1) out_wait--;
    out_ready <= (out_wait == 0);
  end

  // ---------------------------------------------------------------------------
  // Frame builders (generator side)
  // ---------------------------------------------------------------------------
  logic [7:0] frame_chars[$];
  logic [7:0] station;

  task automatic send(input logic [1:0] kind, input logic [7:0] data);
    pending_items.push_back(rx_item_t'{kind, data});
    items_queued++;
  endtask

  function automatic logic [7:0] glyph(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // data and LRC positions are never decoded; mostly hex, some raw bytes
  function automatic logic [7:0] filler();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom) : glyph(4'($urandom));
  endfunction

  task automatic put_hex(input logic [7:0] v);
    frame_chars.push_back(glyph(v[7:4]));
    frame_chars.push_back(glyph(v[3:0]));
  endtask

  // well-formed frame: ':' addr func, then 8 data chars (fixed) or
  // start/quantity + byte count + 2*bc data (wide), LRC pair, CR LF
  task automatic compose(input logic [7:0] addr, input logic [7:0] fn,
                         input logic [7:0] bc);
    int body;
    frame_chars.delete();
    frame_chars.push_back(mafq_pkg::CH_COLON);
    put_hex(addr);
    put_hex(fn);
    if (fn == mafq_pkg::FN_WRITE_COILS || fn == mafq_pkg::FN_WRITE_REGS) begin
      repeat (8) frame_chars.push_back(filler());
      put_hex(bc);
      body = 2 * int'(bc);
    end else begin
      body = 8;
    end
    repeat (body + 2) frame_chars.push_back(filler());
    frame_chars.push_back(mafq_pkg::CH_CR);
    frame_chars.push_back(mafq_pkg::CH_LF);
  endtask

  task automatic ship(input bit close);
    foreach (frame_chars[i]) send(mafq_pkg::KIND_CHAR, frame_chars[i]);
    if (close) send(mafq_pkg::KIND_END, 8'($urandom));
  endtask

  task automatic release_frame();
    send(mafq_pkg::KIND_RELEASE, 8'($urandom));
  endtask

  // wait until every item is taken and every verdict checked, then let the
  // pipeline drain
  task automatic settle();
    while (items_accepted != items_queued || verdicts_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_station(input logic [7:0] addr);
    station = addr;
    @(negedge clk);
    cfg_we            <= 1'b1;
    cfg_slave_address <= addr;
    @(negedge clk);
    cfg_we            <= 1'b0;
  endtask

  // mostly well-formed frames to the configured station with random
  // content; the rest garbled, merged, truncated or oversized
  task automatic random_traffic(input int budget, input bit force_overflow);
    int         first;
    int         k;
    int         mutation;
    logic [7:0] addr;
    logic [7:0] fn;
    logic [7:0] bc;
    first = items_queued;
    while (items_queued - first < budget) begin
      addr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : station;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: fn = 8'($urandom_range(1, 6));
        5, 6:          fn = mafq_pkg::FN_WRITE_COILS;
        7, 8:          fn = mafq_pkg::FN_WRITE_REGS;
        default:       fn = 8'($urandom);
      endcase
      bc = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
      compose(addr, fn, bc);
      mutation = $urandom_range(0, 19);
      case (mutation)
        0: frame_chars.insert($urandom_range(5, frame_chars.size() - 3), filler());
        1: frame_chars.delete($urandom_range(5, frame_chars.size() - 3));
        2: frame_chars[$urandom_range(1, 4)] = 8'($urandom);
        3: frame_chars[0] = 8'($urandom);
        4: frame_chars[frame_chars.size() - 1 - $urandom_range(0, 1)] = 8'($urandom);
        5: begin
          k = $urandom_range(0, 6);
          while (frame_chars.size() > k) frame_chars.delete(frame_chars.size() - 1);
        end
        default: ;
      endcase
      // long frame straddling the buffer limit
      if (force_overflow || $urandom_range(0, 199) == 0) begin
        force_overflow = 1'b0;
        k = $urandom_range(mafq_pkg::MAX_FRAME_LEN - 2, mafq_pkg::MAX_FRAME_LEN + 18);
        while (frame_chars.size() < k) frame_chars.insert(5, filler());
      end
      // mutation 6: no line-idle, so the characters run into the next frame
      ship(mutation != 6);
      if ($urandom_range(0, 2) != 0) release_frame();
      case ($urandom_range(0, 15))
        0: send(KIND_NOISE, 8'($urandom));
        1: send(mafq_pkg::KIND_END, 8'($urandom));
        2: send(mafq_pkg::KIND_CHAR, 8'($urandom));
        default: ;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int ph;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    station = mafq_pkg::RESET_ADDR;

    // directed: runs against the reset-time station address
    send(mafq_pkg::KIND_END, 8'h00);                        // empty frame
    compose(station, 8'h03, 8'h00); ship(1'b1);             // accepted
    compose(station, 8'h03, 8'h00); ship(1'b1);             // busy, chars dropped
    release_frame();
    release_frame();                                         // nothing pending
    send(KIND_NOISE, 8'hFF);
    compose(station, mafq_pkg::FN_FIRST_FIXED, 8'h00); ship(1'b1); release_frame();
    compose(station, mafq_pkg::FN_LAST_FIXED, 8'h00);  ship(1'b1); release_frame();
    compose(station, mafq_pkg::FN_WRITE_COILS, 8'h00); ship(1'b1); release_frame();
    compose(station, mafq_pkg::FN_WRITE_REGS, 8'h03);  ship(1'b1); release_frame();
    compose(station + 8'd1, 8'h03, 8'h00); ship(1'b1);      // wrong address
    compose(station, 8'h00, 8'h00); ship(1'b1);             // unsupported function
    compose(station, 8'h07, 8'h00); ship(1'b1);
    compose(station, 8'hFF, 8'h00); ship(1'b1);
    compose(station, 8'h04, 8'h00);                          // one char too many
    frame_chars.insert(6, filler()); ship(1'b1);
    compose(station, mafq_pkg::FN_WRITE_REGS, 8'h02);        // one char short
    frame_chars.delete(16); ship(1'b1);
    compose(station, 8'h02, 8'h00);                          // no leading colon
    frame_chars[0] = 8'h3B; ship(1'b1);
    compose(station, 8'h02, 8'h00);                          // CR CR ending
    frame_chars[frame_chars.size() - 1] = mafq_pkg::CH_CR; ship(1'b1);
    // too short for delimiters
    frame_chars = '{mafq_pkg::CH_COLON, mafq_pkg::CH_LF}; ship(1'b1);
    // delimiters only
    frame_chars = '{mafq_pkg::CH_COLON, mafq_pkg::CH_CR, mafq_pkg::CH_LF}; ship(1'b1);
    compose(station, 8'h03, 8'h00);                          // non-hex in address
    frame_chars[mafq_pkg::POS_ADDR_LO] = 8'h47; ship(1'b1);
    compose(station, mafq_pkg::FN_WRITE_REGS, 8'h02);        // non-hex in byte count
    frame_chars[mafq_pkg::POS_BC_HI] = 8'h7A; ship(1'b1);

    random_traffic(RANDOM_ITEMS / PHASES, 1'b0);

    // later phases: address extremes first, then random ones
    for (ph = 1; ph < PHASES; ph++) begin
      settle();
      case (ph)
        1:       write_station(8'h00);
        2:       write_station(8'hFF);
        default: write_station(8'($urandom));
      endcase
      random_traffic(RANDOM_ITEMS / PHASES, ph == 2);
    end

    settle();
    if (mismatches == 0) begin
      $display("modbus_ascii_frame_qualifier_core regression: pass");
    end else begin
      $display("modbus_ascii_frame_qualifier_core regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("modbus_ascii_frame_qualifier_core regression: fail");
    $finish;
  end

endmodule
